// ----- rtl/abct_pkg.sv -----
// Shared types, codes and helpers for the alternating-bit peer table.
package abct_pkg;

	localparam int SLOT_W     = 8;
	localparam int RES_SLOT_W = 4;

	localparam logic [1:0] MODE_RX   = 2'd0;
	localparam logic [1:0] MODE_SEND = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic [2:0] KIND_ACK     = 3'd0;
	localparam logic [2:0] KIND_DELIVER = 3'd1;
	localparam logic [2:0] KIND_DATA    = 3'd2;
	localparam logic [2:0] KIND_RETX    = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;
	localparam logic [2:0] KIND_FULL    = 3'd5;

	localparam logic [7:0] HDR_ACK_FLAG  = 8'h80;
	localparam logic [7:0] HDR_DATA_FLAG = 8'h02;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
		logic [7:0]  rx_header;
		logic        remove_after;
	} cmd_t;

	typedef struct packed {
		logic [2:0]            kind;
		logic [31:0]           out_addr;
		logic [15:0]           out_port;
		logic [7:0]            tx_header;
		logic [RES_SLOT_W-1:0] slot;
		logic                  last;
	} res_t;

	// transaction travelling down the row of cells
	typedef struct packed {
		logic              active;
		logic [1:0]        mode;
		logic [31:0]       addr;
		logic [15:0]       port;
		logic              seq;
		logic              is_ack;
		logic              remove;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic [1:0]        hit_phase;
		logic              hit_expect;
		logic              free_found;
		logic [SLOT_W-1:0] free_slot;
	} chain_t;

	typedef enum logic [2:0] {
		UPD_INSERT,
		UPD_ACKED,
		UPD_TOGGLE,
		UPD_SENT,
		UPD_REMOVE
	} upd_op_t;

	typedef struct packed {
		logic              en;
		upd_op_t           op;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       addr;
		logic [15:0]       port;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SECOND
	} state_t;

	function automatic res_t mk_res(input logic [2:0] kind, input logic [31:0] addr,
			input logic [15:0] port, input logic [7:0] hdr,
			input logic [RES_SLOT_W-1:0] slot, input logic last);
		res_t r;
		r.kind      = kind;
		r.out_addr  = addr;
		r.out_port  = port;
		r.tx_header = hdr;
		r.slot      = slot;
		r.last      = last;
		return r;
	endfunction

	function automatic logic [7:0] data_hdr(input logic seq_bit);
		return HDR_DATA_FLAG | {7'd0, seq_bit};
	endfunction

endpackage

// ----- rtl/abct_cell.sv -----
// One peer entry of the table: match, free-slot, timer and update logic.
module abct_cell import abct_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  chain_t      chain_i,
	input  upd_t        upd,
	input  logic [15:0] limit,
	output chain_t      chain_o,
	output res_t        emit,
	output logic        emit_valid
);

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic        valid_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic [1:0]  phase_q;
	logic        expect_q;
	logic        run_q;
	logic [15:0] age_q;

	chain_t      chain_d;
	logic        match;
	logic        tick_here;
	logic        expire;
	logic [15:0] age_inc;
	logic [1:0]  prev_phase;
	logic        upd_here;

	always_comb begin
		match      = valid_q && addr_q == chain_i.addr && port_q == chain_i.port;
		tick_here  = chain_i.active && chain_i.mode == MODE_TICK && valid_q && run_q;
		age_inc    = (age_q == 16'hFFFF) ? age_q : age_q + 16'd1;
		expire     = tick_here && age_inc >= limit;
		prev_phase = phase_q - 2'd1;
		upd_here   = upd.en && upd.slot == MY_SLOT;

		chain_d = chain_i;
		if (chain_i.active && (chain_i.mode == MODE_RX || chain_i.mode == MODE_SEND)) begin
			if (match && !chain_i.hit) begin
				chain_d.hit        = 1'b1;
				chain_d.hit_slot   = MY_SLOT;
				chain_d.hit_phase  = phase_q;
				chain_d.hit_expect = expect_q;
			end
			if (!valid_q && !chain_i.free_found) begin
				chain_d.free_found = 1'b1;
				chain_d.free_slot  = MY_SLOT;
			end
		end

		emit_valid = expire;
		emit       = '0;
		if (expire) begin
			emit = mk_res(KIND_RETX, addr_q, port_q, data_hdr(prev_phase[1]),
				MY_SLOT[RES_SLOT_W-1:0], 1'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_o <= '0;
			valid_q <= 1'b0;
		end else begin
			chain_o <= chain_d;
			if (upd_here) begin
				unique case (upd.op)
					UPD_INSERT: valid_q <= 1'b1;
					UPD_REMOVE: valid_q <= 1'b0;
					default:    valid_q <= valid_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_here) begin
			age_q <= expire ? 16'd0 : age_inc;
		end
		if (upd_here) begin
			unique case (upd.op)
				UPD_INSERT: begin
					addr_q   <= upd.addr;
					port_q   <= upd.port;
					phase_q  <= 2'd0;
					expect_q <= 1'b1;
					run_q    <= 1'b0;
					age_q    <= 16'd0;
				end
				UPD_ACKED: begin
					run_q   <= 1'b0;
					phase_q <= phase_q + 2'd1;
				end
				UPD_TOGGLE: expect_q <= ~expect_q;
				UPD_SENT: begin
					phase_q <= phase_q + 2'd1;
					run_q   <= 1'b1;
					age_q   <= 16'd0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/alternating_bit_client_table.sv -----
// Top level of the alternating-bit peer table: command port, cell row, result sequencing.
//
// Command channel: a transaction is taken at a clock edge with start high and busy
// low; cmd carries mode, peer address and port, received header and remove flag.
// Results appear on res for one cycle each, marked by res_valid; res.last flags the
// final result of a command. The receiver cannot stall, none is needed.
// Config channel: cfg_data (retransmit ticks) is written whenever cfg_valid is high;
// cfg_ready is always high. Write only while busy is low.
// Row walk: the command passes the row of PEERS cells, one cell per cycle. The first
// result of a receive or send is registered from the output of the last cell;
// a second result (deliver then ACK) follows in the next cycle. busy falls with the
// last result. A tick streams retransmits in slot order while the walk goes on;
// each is held back until the next expiring cell is reached, and the one marked
// last is registered from the output of the last cell like the other results.
// Commands that yield nothing still walk the whole row before busy falls.
// Reset clears every entry's valid bit and sets the retransmit limit to 1.
module alternating_bit_client_table import abct_pkg::*; #(
	parameter int PEERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        res_valid,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	state_t      state_q, state_d;
	chain_t      head_q, head_d;
	res_t        res_q, res_d;
	logic        res_valid_q, res_valid_d;
	res_t        second_q, second_d;
	res_t        pend_q, pend_d;
	logic        pend_v_q, pend_v_d;
	logic [15:0] limit_q;
	logic [15:0] limit_eff;
	upd_t        upd;

	chain_t      links [PEERS+1];
	res_t        emits [PEERS];
	logic        emit_v [PEERS];
	res_t        emit_res;
	logic        emit_any;
	chain_t      tail;
	logic        ack_ok;

	assign cfg_ready = 1'b1;
	assign busy      = state_q != ST_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign limit_eff = (limit_q == 16'd0) ? 16'd1 : limit_q;
	assign links[0]  = head_q;
	assign tail      = links[PEERS];

	for (genvar i = 0; i < PEERS; i++) begin : g_cell
		abct_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.chain_i   (links[i]),
			.upd       (upd),
			.limit     (limit_eff),
			.chain_o   (links[i+1]),
			.emit      (emits[i]),
			.emit_valid(emit_v[i])
		);
	end

	always_comb begin
		emit_res = '0;
		emit_any = 1'b0;
		for (int i = 0; i < PEERS; i++) begin
			emit_res = emit_res | emits[i];
			emit_any = emit_any | emit_v[i];
		end
	end

	always_comb begin
		state_d     = state_q;
		head_d      = '0;
		res_d       = '0;
		res_valid_d = 1'b0;
		second_d    = second_q;
		pend_d      = pend_q;
		pend_v_d    = pend_v_q;
		upd         = '0;
		ack_ok      = (!tail.seq && tail.hit_phase == 2'd1) ||
			(tail.seq && tail.hit_phase == 2'd3);

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					head_d.active = 1'b1;
					head_d.mode   = cmd.mode;
					head_d.addr   = cmd.peer_addr;
					head_d.port   = cmd.peer_port;
					head_d.seq    = cmd.rx_header[0];
					head_d.is_ack = cmd.rx_header[7];
					head_d.remove = cmd.remove_after;
					pend_v_d      = 1'b0;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (emit_any) begin
					if (pend_v_q) begin
						res_d       = pend_q;
						res_valid_d = 1'b1;
					end
					pend_d   = emit_res;
					pend_v_d = 1'b1;
				end
				if (tail.active) begin
					state_d   = ST_IDLE;
					upd.addr  = tail.addr;
					upd.port  = tail.port;
					upd.slot  = tail.hit_slot;
					case (tail.mode)
						MODE_RX: begin
							if (tail.hit) begin
								if (tail.is_ack) begin
									if (ack_ok) begin
										upd.en = 1'b1;
										upd.op = UPD_ACKED;
									end
								end else begin
									second_d = mk_res(KIND_ACK, tail.addr, tail.port,
										HDR_ACK_FLAG | {7'd0, tail.seq},
										tail.hit_slot[RES_SLOT_W-1:0], 1'b1);
									res_valid_d = 1'b1;
									if (tail.seq == tail.hit_expect) begin
										upd.en  = 1'b1;
										upd.op  = UPD_TOGGLE;
										res_d   = mk_res(KIND_DELIVER, tail.addr, tail.port,
											8'd0, tail.hit_slot[RES_SLOT_W-1:0], 1'b0);
										state_d = ST_SECOND;
									end else begin
										res_d = second_d;
									end
								end
							end else if (!tail.is_ack) begin
								res_valid_d = 1'b1;
								if (tail.free_found) begin
									upd.en   = 1'b1;
									upd.op   = UPD_INSERT;
									upd.slot = tail.free_slot;
									res_d    = mk_res(KIND_DELIVER, tail.addr, tail.port,
										8'd0, tail.free_slot[RES_SLOT_W-1:0], 1'b0);
									second_d = mk_res(KIND_ACK, tail.addr, tail.port,
										HDR_ACK_FLAG | {7'd0, tail.seq},
										tail.free_slot[RES_SLOT_W-1:0], 1'b1);
									state_d  = ST_SECOND;
								end else begin
									res_d = mk_res(KIND_FULL, tail.addr, tail.port, 8'd0,
										'0, 1'b1);
								end
							end
						end
						MODE_SEND: begin
							res_valid_d = 1'b1;
							if (tail.hit) begin
								upd.en = 1'b1;
								upd.op = tail.remove ? UPD_REMOVE : UPD_SENT;
								res_d  = mk_res(KIND_DATA, tail.addr, tail.port,
									data_hdr(tail.hit_phase[1]),
									tail.hit_slot[RES_SLOT_W-1:0], 1'b1);
							end else begin
								res_d = mk_res(KIND_UNKNOWN, tail.addr, tail.port, 8'd0,
									'0, 1'b1);
							end
						end
						MODE_TICK: begin
							if (pend_v_q) begin
								res_d       = pend_q;
								res_d.last  = 1'b1;
								res_valid_d = 1'b1;
								pend_v_d    = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SECOND: begin
				res_d       = second_q;
				res_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			res_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			limit_q     <= 16'd1;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			res_valid_q <= res_valid_d;
			pend_v_q    <= pend_v_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_d;
		second_q <= second_d;
		pend_q   <= pend_d;
	end

endmodule

// ----- rtl/abct_checker.sv -----
// Port-level checks for the alternating-bit peer table, bound to the top level.
module abct_checker import abct_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        res_valid,
	input res_t        res
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command");

	a_quiet_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !res_valid)
		else $error("result too soon after command");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |=> !res_valid)
		else $error("result after last");

	a_deliver_then_ack: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_DELIVER |=>
			res_valid && res.kind == KIND_ACK && res.last && res.slot == $past(res.slot))
		else $error("deliver not followed by ACK");

	a_full_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_FULL |-> res.last && res.slot == '0 && !busy)
		else $error("malformed table-full result");

endmodule

bind alternating_bit_client_table abct_checker u_abct_checker (.*);
